// File: rtl/line_follow_centroid_pid_macros.svh
// Assertion shorthands for the line follower checker.
// Every assertion is sampled on i_clk and is switched off while i_rst_n is low.
`ifndef LINE_FOLLOW_CENTROID_PID_MACROS_SVH
`define LINE_FOLLOW_CENTROID_PID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/lfc_pkg.sv
package lfc_pkg;

    // Number of robots that keep a control history.
    localparam int ROBOTS     = 8;
    localparam int IDX_W      = 3;

    // Datapath widths.
    localparam int LEVEL_W    = 8;
    localparam int SUM_W      = 10;
    localparam int NUM_W      = 24;
    localparam int QUOT_W     = 16;
    localparam int ERR_W      = 17;
    localparam int INTEG_W    = 20;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int OPND_W     = 21;
    localparam int PROD_W     = GAIN_W + 1 + OPND_W;
    localparam int ACC_W      = 40;
    localparam int FRAC_W     = 20;
    localparam int CMAG_W     = ACC_W - FRAC_W;

    // One quotient bit is formed per divider step.
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int MUL_TERMS  = 3;

    // Register file.
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam logic [2:0] REG_ERROR_SCALE = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED  = 3'd1;
    localparam logic [2:0] REG_GAIN_PROP   = 3'd2;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd3;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd4;

    // Operand select codes of the shared multiplier.
    localparam logic [1:0] MUL_PROP  = 2'd0;
    localparam logic [1:0] MUL_INTEG = 2'd1;
    localparam logic [1:0] MUL_DERIV = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]   robot_index;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] center_level;
        logic [LEVEL_W-1:0] right_level;
        logic               clear_history;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   robot_for;
        logic [LEVEL_W-1:0] left_speed;
        logic [LEVEL_W-1:0] right_speed;
        logic               speed_saturated;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        error_scale;
        logic [7:0]        base_speed;
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
    } t_cfg;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       err_en;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       out_load;
    } t_dp_cmd;

endpackage

// File: rtl/line_follow_centroid_pid.sv
// Channel    Direction  Handshake                  Payload
// request    in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// result     out        o_out_valid / i_out_ready  o_out_data (t_out_item)
// config     in         psel, penable, pwrite      paddr, pwdata, prdata
//
// Each request passes in order through the restoring divider (one quotient bit a
// cycle), the error and history step, the shared multiplier and accumulator, and
// the load of the result register. A request is taken only in the idle state, so a
// new one is not accepted before the result of the last has been loaded.
// Reset is synchronous, active low; it resets sequencer, config and all robot history.
// A new request is accepted while an earlier result still waits in the output
// register; a stalled result only holds the sequencer at the final load.
module line_follow_centroid_pid
    import lfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    // Configuration registers.
    lfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer.
    lfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Divider, multiplier, history and result register.
    lfc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// File: rtl/lfc_regs.sv
module lfc_regs
    import lfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_scale <= 8'd100;
            r_cfg.base_speed  <= 8'd200;
            r_cfg.gain_prop   <= 16'd4096;
            r_cfg.gain_integ  <= 16'd328;
            r_cfg.gain_deriv  <= 16'd41;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ERROR_SCALE: r_cfg.error_scale <= pwdata[7:0];
                REG_BASE_SPEED:  r_cfg.base_speed  <= pwdata[7:0];
                REG_GAIN_PROP:   r_cfg.gain_prop   <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG:  r_cfg.gain_integ  <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:  r_cfg.gain_deriv  <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_ERROR_SCALE: prdata = {24'd0, r_cfg.error_scale};
            REG_BASE_SPEED:  prdata = {24'd0, r_cfg.base_speed};
            REG_GAIN_PROP:   prdata = {16'd0, r_cfg.gain_prop};
            REG_GAIN_INTEG:  prdata = {16'd0, r_cfg.gain_integ};
            REG_GAIN_DERIV:  prdata = {16'd0, r_cfg.gain_deriv};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/lfc_ctrl.sv
module lfc_ctrl
    import lfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_TERMS - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_cnt        = '0;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc_clr = (r_cnt == '0);
                o_cmd.acc_add = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/lfc_dp.sv
module lfc_dp
    import lfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    // Per-robot history.
    logic signed [INTEG_W-1:0] r_hist_integ [ROBOTS];
    logic signed [ERR_W-1:0]   r_hist_err   [ROBOTS];

    // Working registers of the current request.
    logic [IDX_W-1:0]          r_idx;
    logic                      r_idx_ok;
    logic                      r_neg;
    logic                      r_sum_zero;
    logic [SUM_W-1:0]          r_sum;
    logic [NUM_W-1:0]          r_q;
    logic [SUM_W-1:0]          r_rem;
    logic signed [INTEG_W-1:0] r_s_old;
    logic signed [ERR_W-1:0]   r_e_old;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_out_item                 r_out;

    logic                      in_idx_ok;
    logic [SUM_W-1:0]          in_sum;
    logic                      in_neg;
    logic [LEVEL_W-1:0]        in_mag;
    logic [2*LEVEL_W-1:0]      in_scaled;

    logic [SUM_W:0]            trial;
    logic                      trial_ge;
    logic [SUM_W:0]            trial_sub;

    logic signed [ERR_W-1:0]   e_mag;
    logic signed [ERR_W-1:0]   e_val;
    logic signed [INTEG_W-1:0] s_val;
    logic signed [DIFF_W-1:0]  d_val;

    logic signed [OPND_W-1:0]  mul_opnd;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [GAIN_W:0]    mul_gain_s;

    logic                      c_neg;
    logic [ACC_W-1:0]          a_mag;
    logic [CMAG_W-1:0]         c_mag;
    logic [CMAG_W-1:0]         spd;
    logic                      sat;
    logic [LEVEL_W-1:0]        clip;

    // Input decode: centroid numerator and sensor sum.
    assign in_idx_ok = ({1'b0, i_in_data.robot_index} < (IDX_W + 1)'(ROBOTS));
    assign in_sum    = SUM_W'(i_in_data.left_level) + SUM_W'(i_in_data.center_level)
                     + SUM_W'(i_in_data.right_level);
    assign in_neg    = i_in_data.right_level < i_in_data.left_level;
    assign in_mag    = in_neg ? (i_in_data.left_level - i_in_data.right_level)
                              : (i_in_data.right_level - i_in_data.left_level);
    assign in_scaled = i_cfg.error_scale * in_mag;

    // Restoring divider step: one quotient bit per cycle.
    assign trial     = {r_rem, r_q[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, r_sum};
    assign trial_sub = trial - {1'b0, r_sum};

    // Signed error, leaky integral and error difference.
    assign e_mag = $signed({1'b0, r_q[QUOT_W-1:0]});
    assign e_val = r_sum_zero ? '0 : (r_neg ? -e_mag : e_mag);
    assign s_val = (r_s_old >>> 1)
                 + $signed({{(INTEG_W-ERR_W){e_val[ERR_W-1]}}, e_val});
    assign d_val = {e_val[ERR_W-1], e_val} - {r_e_old[ERR_W-1], r_e_old};

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_PROP: begin
                mul_opnd = {{(OPND_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                mul_gain = i_cfg.gain_prop;
            end
            MUL_INTEG: begin
                mul_opnd = {{(OPND_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ};
                mul_gain = i_cfg.gain_integ;
            end
            MUL_DERIV: begin
                mul_opnd = {{(OPND_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_gain = i_cfg.gain_deriv;
            end
            default: begin
                mul_opnd = '0;
                mul_gain = '0;
            end
        endcase
    end
    assign mul_gain_s = $signed({1'b0, mul_gain});

    // Actuation magnitude and wheel speed clipping.
    assign c_neg = r_acc[ACC_W-1];
    assign a_mag = c_neg ? (-r_acc) : r_acc;
    assign c_mag = a_mag[ACC_W-1:FRAC_W];
    assign spd   = CMAG_W'(i_cfg.base_speed) + c_mag;
    assign sat   = |spd[CMAG_W-1:LEVEL_W];
    assign clip  = sat ? {LEVEL_W{1'b1}} : spd[LEVEL_W-1:0];

    // Per-robot history, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROBOTS; k++) begin
                r_hist_integ[k] <= '0;
                r_hist_err[k]   <= '0;
            end
        end else if (i_cmd.err_en && r_idx_ok) begin
            r_hist_integ[r_idx] <= s_val;
            r_hist_err[r_idx]   <= e_val;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx      <= i_in_data.robot_index;
            r_idx_ok   <= in_idx_ok;
            r_neg      <= in_neg;
            r_sum      <= in_sum;
            r_sum_zero <= (in_sum == '0);
            r_q        <= {in_scaled, 8'd0};
            r_rem      <= '0;
            if (in_idx_ok && !i_in_data.clear_history) begin
                r_s_old <= r_hist_integ[i_in_data.robot_index];
                r_e_old <= r_hist_err[i_in_data.robot_index];
            end else begin
                r_s_old <= '0;
                r_e_old <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], trial_ge};
        end

        if (i_cmd.err_en) begin
            r_err   <= e_val;
            r_integ <= s_val;
            r_diff  <= d_val;
        end

        if (i_cmd.mul_en) begin
            r_prod <= mul_gain_s * mul_opnd;
        end

        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end

        if (i_cmd.out_load) begin
            r_out.robot_for       <= r_idx;
            r_out.left_speed      <= c_neg ? clip : i_cfg.base_speed;
            r_out.right_speed     <= c_neg ? i_cfg.base_speed : clip;
            r_out.speed_saturated <= sat;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: rtl/lfc_checker.sv
`include "line_follow_centroid_pid_macros.svh"

module lfc_checker
    import lfc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_in_item           i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // A stalled result keeps its payload.
    `LFC_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data))

    // One request at a time: the block is busy right after taking one.
    `LFC_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready)

    // A result never appears in the cycle after a request is taken.
    `LFC_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(o_out_valid))

    // A clipped speed always sits at full scale on one wheel.
    `LFC_ASSERT_SAME(a_sat_full_scale, o_out_valid && o_out_data.speed_saturated,
        o_out_data.left_speed == 8'hFF || o_out_data.right_speed == 8'hFF)

endmodule

bind line_follow_centroid_pid lfc_checker u_lfc_checker (.*);

// File: verif/line_follow_centroid_pid_test.sv
`timescale 1ns / 1ps

module line_follow_centroid_pid_test;
    import lfc_pkg::*;

    localparam int HANG_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 5;
    // Register index beyond the map; a write there must change nothing.
    localparam logic [2:0] REG_UNMAPPED = 3'd5;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Requests waiting to be sent and speed results waiting to arrive.
    t_in_item  pending_requests[$];
    t_out_item expected_speeds[$];

    // Shadow copy of the registers and of every robot's control history.
    t_cfg ctrl_cfg;
    int   integ_hist[ROBOTS];
    int   err_hist[ROBOTS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int hang_count     = 0;

    line_follow_centroid_pid DUT (.*);

    always #10 i_clk = ~i_clk;

    // Predict the wheel speeds of one request and advance that robot's history.
    function automatic t_out_item predict_speeds(t_in_item req);
        int unsigned level_sum;
        int unsigned spread;
        int          err;
        int          integ;
        int          err_old;
        longint      drive;
        longint      left_spd;
        longint      right_spd;
        bit          drive_neg;
        t_out_item   res;
        if (req.clear_history) begin
            integ_hist[req.robot_index] = 0;
            err_hist[req.robot_index]   = 0;
        end
        err_old   = err_hist[req.robot_index];
        level_sum = req.left_level + req.center_level + req.right_level;

        // Weighted centroid in Q8.8, truncated toward zero; zero when all levels are dark.
        err = 0;
        if (level_sum != 0) begin
            if (req.right_level >= req.left_level) begin
                spread = req.right_level - req.left_level;
            end else begin
                spread = req.left_level - req.right_level;
            end
            err = int'((ctrl_cfg.error_scale * spread * 256) / level_sum);
            if (req.right_level < req.left_level) begin
                err = -err;
            end
        end

        // Leaky integral: floor of half the old value, plus the new error.
        integ = (integ_hist[req.robot_index] >>> 1) + err;
        integ_hist[req.robot_index] = integ;
        err_hist[req.robot_index]   = err;

        // Exact Q20.20 sum, magnitude truncated to whole speed steps.
        drive = longint'(ctrl_cfg.gain_prop) * err
              + longint'(ctrl_cfg.gain_integ) * integ
              + longint'(ctrl_cfg.gain_deriv) * (err - err_old);
        drive_neg = (drive < 0);
        if (drive_neg) begin
            drive = -drive;
        end
        drive = drive >>> 20;

        left_spd  = ctrl_cfg.base_speed;
        right_spd = ctrl_cfg.base_speed;
        if (drive_neg) begin
            left_spd = left_spd + drive;
        end else begin
            right_spd = right_spd + drive;
        end

        res.robot_for       = req.robot_index;
        res.speed_saturated = (left_spd > 255) || (right_spd > 255);
        res.left_speed      = (left_spd > 255) ? 8'hFF : 8'(left_spd);
        res.right_speed     = (right_spd > 255) ? 8'hFF : 8'(right_spd);
        return res;
    endfunction

    // Random request: mostly random levels, some dark, single-sensor or centred-line ones.
    function automatic t_in_item random_request();
        t_in_item req;
        req.robot_index   = IDX_W'($urandom_range(ROBOTS - 1));
        req.clear_history = ($urandom_range(15) == 0);
        req.left_level    = LEVEL_W'($urandom_range(255));
        req.center_level  = LEVEL_W'($urandom_range(255));
        req.right_level   = LEVEL_W'($urandom_range(255));
        case ($urandom_range(9))
            0: begin
                req.left_level   = '0;
                req.center_level = '0;
                req.right_level  = '0;
            end
            1: begin
                req.center_level = '0;
                if ($urandom_range(1) == 1) begin
                    req.left_level = '0;
                end else begin
                    req.right_level = '0;
                end
            end
            2, 3: begin
                req.center_level = LEVEL_W'($urandom_range(255, 160));
                req.left_level   = LEVEL_W'($urandom_range(60));
                req.right_level  = LEVEL_W'($urandom_range(60));
            end
            default: begin
            end
        endcase
        return req;
    endfunction

    task automatic queue_request(input int robot, input int left_lvl, input int center_lvl,
                                 input int right_lvl, input bit clear);
        t_in_item req;
        req.robot_index   = IDX_W'(robot);
        req.left_level    = LEVEL_W'(left_lvl);
        req.center_level  = LEVEL_W'(center_lvl);
        req.right_level   = LEVEL_W'(right_lvl);
        req.clear_history = clear;
        pending_requests  = {pending_requests, req};
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] index, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ERROR_SCALE: ctrl_cfg.error_scale = value[7:0];
            REG_BASE_SPEED:  ctrl_cfg.base_speed  = value[7:0];
            REG_GAIN_PROP:   ctrl_cfg.gain_prop   = value[GAIN_W-1:0];
            REG_GAIN_INTEG:  ctrl_cfg.gain_integ  = value[GAIN_W-1:0];
            REG_GAIN_DERIV:  ctrl_cfg.gain_deriv  = value[GAIN_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_cfg(input logic [7:0] scale, input logic [7:0] base,
                             input logic [15:0] prop, input logic [15:0] integ,
                             input logic [15:0] deriv);
        write_register(REG_ERROR_SCALE, {24'd0, scale});
        write_register(REG_BASE_SPEED, {24'd0, base});
        write_register(REG_GAIN_PROP, {16'd0, prop});
        write_register(REG_GAIN_INTEG, {16'd0, integ});
        write_register(REG_GAIN_DERIV, {16'd0, deriv});
    endtask

    // Block until every queued request has been sent and every result has come back.
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_speeds.size() != 0);
    endtask

    // Request driver: presents queued requests and predicts each one accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_speeds = {expected_speeds, predict_speeds(i_in_data)};
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_requests.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_speeds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result: robot %0d left %0d right %0d sat %0b",
                             o_out_data.robot_for, o_out_data.left_speed,
                             o_out_data.right_speed, o_out_data.speed_saturated);
                end
            end else begin
                want = expected_speeds.pop_front();
                if (o_out_data.robot_for !== want.robot_for
                        || o_out_data.left_speed !== want.left_speed
                        || o_out_data.right_speed !== want.right_speed
                        || o_out_data.speed_saturated !== want.speed_saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        // Fields in order: robot, left speed, right speed, saturated.
                        $display("Mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 want.robot_for, want.left_speed, want.right_speed,
                                 want.speed_saturated, o_out_data.robot_for,
                                 o_out_data.left_speed, o_out_data.right_speed,
                                 o_out_data.speed_saturated);
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: while work is outstanding, some handshake must complete now and then.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            hang_count <= 0;
        end else if (pending_requests.size() != 0 || i_in_valid
                     || expected_speeds.size() != 0) begin
            if (hang_count >= HANG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                hang_count <= hang_count + 1;
            end
        end
    end

    // Test sequence: directed requests at reset settings, then random phases.
    initial begin
        int phase_items[PHASES] = '{170, 60, 150, 150, 150};
        ctrl_cfg = '{error_scale: 8'd100, base_speed: 8'd200, gain_prop: 16'd4096,
                     gain_integ: 16'd328, gain_deriv: 16'd41};
        for (int k = 0; k < ROBOTS; k++) begin
            integ_hist[k] = 0;
            err_hist[k]   = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dark sensors, full swings both ways, clears on built-up history, clipping.
        @(negedge i_clk);
        queue_request(0, 0, 0, 0, 1);
        queue_request(0, 255, 0, 0, 0);
        queue_request(0, 0, 0, 255, 0);
        queue_request(1, 255, 255, 255, 0);
        queue_request(1, 0, 255, 0, 0);
        queue_request(2, 1, 0, 0, 0);
        queue_request(2, 0, 0, 1, 0);
        queue_request(3, 128, 64, 0, 0);
        queue_request(3, 0, 64, 128, 0);
        queue_request(3, 0, 64, 128, 1);
        queue_request(4, 85, 170, 85, 0);
        queue_request(5, 255, 0, 254, 0);
        queue_request(6, 10, 20, 200, 0);
        queue_request(7, 200, 20, 10, 0);
        queue_request(7, 255, 0, 0, 1);
        queue_request(4, 0, 0, 0, 0);
        queue_request(5, 170, 85, 170, 1);
        queue_request(6, 255, 255, 0, 0);
        queue_request(0, 0, 255, 255, 0);
        queue_request(1, 37, 200, 90, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            case (phase)
                0: begin
                    apply_cfg(8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
                end
                1: apply_cfg(8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
                2, 3: apply_cfg(8'($urandom_range(255)), 8'($urandom_range(255)),
                                16'($urandom_range(16384)), 16'($urandom_range(4096)),
                                16'($urandom_range(65535)));
                default: apply_cfg(8'd100, 8'd200, 16'd4096, 16'd328, 16'd41);
            endcase
            @(negedge i_clk);
            case (phase % 4)
                1: begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                3: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (phase_items[phase]) pending_requests = {pending_requests, random_request()};
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_speeds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
